// ----- hdl/lj_pkg.sv -----
package lj_pkg;

    // Arithmetic width of the generator and digit width of the shared multiplier.
    localparam int LJ_SEED_BITS = 32;
    localparam int LJ_DIGIT     = 16;

    // Field and register widths.
    localparam int FIELD_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = CFG_IDX_W'(1);

    // Register reset values.
    localparam logic [FIELD_W-1:0] MULTIPLIER_RESET = 32'h0003_43FD;
    localparam logic [FIELD_W-1:0] INCREMENT_RESET  = 32'h0026_9EC3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_ACC_MUL,
        S_ACC_ADD,
        S_CUR_ADD,
        S_CUR_MUL,
        S_FINAL,
        S_PUT
    } t_state;

    // Status of the shared multiply-add unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

endpackage

// ----- hdl/lj_mul.sv -----
module lj_mul
    import lj_pkg::*;
#(
    parameter int W = LJ_SEED_BITS,
    parameter int D = LJ_DIGIT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_addend,
    output t_mul_sts     o_sts,
    output logic [W-1:0] o_result
);

    localparam int NDIG = (W + D - 1) / D;
    localparam int BW   = NDIG * D;
    localparam int CW   = $clog2(NDIG + 1);

    logic [W-1:0]   r_a;
    logic [BW-1:0]  r_b;
    logic [W-1:0]   r_acc;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W+D-1:0] w_pp;

    // One digit of b against the whole of a; the product is kept modulo 2^W.
    assign w_pp = r_a * r_b[D-1:0];

    // Control: count the digits of b and flag the cycle after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(NDIG);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: shift-and-add, one digit a cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BW'(i_b);
            r_acc <= i_addend;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp[W-1:0];
            r_a   <= r_a << D;
            r_b   <= r_b >> D;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = r_acc;

endmodule

// ----- hdl/lcg_jump_ahead.sv -----
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_seed_in, i_steps
// result    out        o_valid / i_stall   o_seed_out
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// Each multiply-add runs in the shared unit, one 16-bit digit of its second operand at a time.
// Per bit of the step count: a decision state, plus two multiply-adds for a clear bit
// or four for a set bit, but two for the highest set bit, after which the loop ends. One final
// multiply-add and the output state follow.
// Reset is synchronous and active low; it restores both registers and empties the output.
// A stalled result is held in the output register; the block takes no new item until done.
module lcg_jump_ahead
    import lj_pkg::*;
#(
    parameter int SEED_BITS = LJ_SEED_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [FIELD_W-1:0]   i_seed_in,
    input  logic [FIELD_W-1:0]   i_steps,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [FIELD_W-1:0]   o_seed_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIELD_W-1:0]   i_cfg_data
);

    localparam int W = SEED_BITS;

    t_state r_state, n_state;

    logic [FIELD_W-1:0] r_cfg_mul;
    logic [FIELD_W-1:0] r_cfg_inc;
    logic [W-1:0]       r_seed;
    logic [FIELD_W-1:0] r_steps;
    logic [W-1:0]       r_acc_mul;
    logic [W-1:0]       r_acc_add;
    logic [W-1:0]       r_cur_mul;
    logic [W-1:0]       r_cur_add;
    logic               r_pend, n_pend;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out;

    logic               w_accept;
    logic               w_op;
    logic               w_start;
    logic               w_put;
    logic [W-1:0]       w_a, w_b, w_addend;
    t_mul_sts           w_sts;
    logic [W-1:0]       w_result;

    assign w_accept = i_valid && !o_stall;
    assign w_put    = (r_state == S_PUT) && (!r_out_valid || !i_stall);

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mul <= MULTIPLIER_RESET;
            r_cfg_inc <= INCREMENT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MULTIPLIER: r_cfg_mul <= i_cfg_data;
                REG_INCREMENT:  r_cfg_inc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_BIT;
            end
            S_BIT: begin
                if (r_steps == '0)   n_state = S_FINAL;
                else if (r_steps[0]) n_state = S_ACC_MUL;
                else                 n_state = S_CUR_ADD;
            end
            S_ACC_MUL: begin
                if (w_sts.done) n_state = S_ACC_ADD;
            end
            S_ACC_ADD: begin
                // After the highest set bit the doubling pair is no longer needed.
                if (w_sts.done) begin
                    n_state = (r_steps[FIELD_W-1:1] == '0) ? S_FINAL : S_CUR_ADD;
                end
            end
            S_CUR_ADD: begin
                if (w_sts.done) n_state = S_CUR_MUL;
            end
            S_CUR_MUL: begin
                if (w_sts.done) n_state = S_BIT;
            end
            S_FINAL: begin
                if (w_sts.done) n_state = S_PUT;
            end
            S_PUT: begin
                if (w_put) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: operand selection and the start of each multiply-add.
    always_comb begin
        w_op     = 1'b0;
        w_a      = r_acc_mul;
        w_b      = r_cur_mul;
        w_addend = '0;
        case (r_state)
            S_ACC_MUL: begin
                w_op = 1'b1;
            end
            S_ACC_ADD: begin
                w_op     = 1'b1;
                w_a      = r_acc_add;
                w_addend = r_cur_add;
            end
            S_CUR_ADD: begin
                w_op = 1'b1;
                w_a  = r_cur_mul + W'(1);
                w_b  = r_cur_add;
            end
            S_CUR_MUL: begin
                w_op = 1'b1;
                w_a  = r_cur_mul;
            end
            S_FINAL: begin
                w_op     = 1'b1;
                w_b      = r_seed;
                w_addend = r_acc_add;
            end
            default: ;
        endcase
    end

    assign w_start = w_op && !r_pend;

    always_comb begin
        n_pend = r_pend;
        if (w_start)     n_pend = 1'b1;
        if (w_sts.done)  n_pend = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // Working registers: load on accept, update from each finished multiply-add of the loop.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seed    <= W'(i_seed_in);
            r_steps   <= i_steps;
            r_acc_mul <= W'(1);
            r_acc_add <= '0;
            r_cur_mul <= W'(r_cfg_mul);
            r_cur_add <= W'(r_cfg_inc);
        end else if (w_sts.done) begin
            case (r_state)
                S_ACC_MUL: r_acc_mul <= w_result;
                S_ACC_ADD: r_acc_add <= w_result;
                S_CUR_ADD: r_cur_add <= w_result;
                S_CUR_MUL: begin
                    r_cur_mul <= w_result;
                    r_steps   <= r_steps >> 1;
                end
                default: ;
            endcase
        end
    end

    lj_mul #(
        .W (W),
        .D (LJ_DIGIT)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_addend (w_addend),
        .o_sts    (w_sts),
        .o_result (w_result)
    );

    // Output register; the unit holds the final value until it is moved here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_put) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_out <= FIELD_W'(w_result);
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_seed_out = r_out;

endmodule

// ----- hdl/lj_chk.sv -----
module lj_chk
    import lj_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [FIELD_W-1:0] o_seed_out
);

    // A result waiting under stall keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_seed_out))
        else $error("result changed or vanished while stalled");

    // Once an item is taken the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block ready straight after taking an item");

    // A new result is produced only while an item is being worked on.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without an item in progress");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind lcg_jump_ahead lj_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_seed_out (o_seed_out)
);
